/* src/lms_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lms_pkg
// Shared types and constants for the lower median select unit.
// ----------------------------------------------------------------------------
package lms_pkg;

  // buffer depth and derived widths
  localparam int unsigned MaxSetSize = 64;
  localparam int unsigned AddrW      = $clog2(MaxSetSize);
  localparam int unsigned CountW     = $clog2(MaxSetSize + 1);
  localparam int unsigned DataW      = 32;
  localparam int unsigned OutCountW  = 7;

  // one finished result
  typedef struct packed {
    logic signed [DataW-1:0]     median;
    logic        [OutCountW-1:0] count;
    logic                        ovf;
  } lms_res_t;

endpackage

/* src/lms_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lms_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lms_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/lms_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lms_core
// Loads a set into the value RAM, then runs an exchange sort pass by pass
// through the RAM until the lower median position is final.
// ----------------------------------------------------------------------------
module lms_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [lms_pkg::DataW-1:0] sample_i,
  input  logic                            last_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output lms_pkg::lms_res_t               res_o
);
  import lms_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PIVOT,
    S_SCAN,
    S_DONE
  } state_e;

  state_e                   state_q;
  logic [CountW-1:0]        fill_q;
  logic                     ovf_seen_q;
  logic [CountW-1:0]        n_q;
  logic                     ovf_q;
  logic [CountW-1:0]        i_q;
  logic [CountW-1:0]        j_q;
  logic                     first_q;
  logic signed [DataW-1:0]  cur_q;

  logic                     accept;
  logic                     ram_we;
  logic [AddrW-1:0]         ram_waddr;
  logic [DataW-1:0]         ram_wdata;
  logic [AddrW-1:0]         ram_raddr;
  logic [DataW-1:0]         ram_rdata;
  logic [CountW-1:0]        median_idx;
  logic [CountW-1:0]        j_prev;
  logic                     swap;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_ready_o = (state_q == S_IDLE);
  assign median_idx = (n_q - 1'b1) >> 1;
  assign j_prev     = j_q - 1'b1;
  assign swap       = !first_q && (cur_q > $signed(ram_rdata));

  // RAM port selection: load writes in idle, swap writes during scan
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill_q[AddrW-1:0];
    ram_wdata = sample_i;
    ram_raddr = j_q[AddrW-1:0];
    case (state_q)
      S_IDLE: begin
        ram_we = accept && (fill_q < CountW'(MaxSetSize));
      end
      S_PIVOT: begin
        ram_raddr = i_q[AddrW-1:0];
      end
      S_SCAN: begin
        ram_we    = swap;
        ram_waddr = j_prev[AddrW-1:0];
        ram_wdata = cur_q;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  lms_ram #(
    .WIDTH(DataW),
    .DEPTH(MaxSetSize)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // sequencer: load, sort passes, hand off result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fill_q     <= '0;
      ovf_seen_q <= 1'b0;
      n_q        <= '0;
      ovf_q      <= 1'b0;
      i_q        <= '0;
      j_q        <= '0;
      first_q    <= 1'b0;
      cur_q      <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (fill_q < CountW'(MaxSetSize)) begin
              fill_q <= fill_q + 1'b1;
            end else begin
              ovf_seen_q <= 1'b1;
            end
            if (last_i) begin
              // latch set size and flag, clear for the next set
              if (fill_q < CountW'(MaxSetSize)) begin
                n_q   <= fill_q + 1'b1;
                ovf_q <= ovf_seen_q;
              end else begin
                n_q   <= fill_q;
                ovf_q <= 1'b1;
              end
              fill_q     <= '0;
              ovf_seen_q <= 1'b0;
              i_q        <= '0;
              state_q    <= S_PIVOT;
            end
          end
        end
        S_PIVOT: begin
          j_q     <= i_q + 1'b1;
          first_q <= 1'b1;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          // take pivot, or exchange with the element just read
          if (first_q || swap) begin
            cur_q <= $signed(ram_rdata);
          end
          first_q <= 1'b0;
          if (j_q < n_q) begin
            j_q <= j_q + 1'b1;
          end else if (i_q == median_idx) begin
            state_q <= S_DONE;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= S_PIVOT;
          end
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign res_valid_o  = (state_q == S_DONE);
  assign res_o.median = cur_q;
  assign res_o.count  = OutCountW'(n_q);
  assign res_o.ovf    = ovf_q;

endmodule

/* src/lower_median_select_unit.sv */
`timescale 1ns / 1ps
// Ranking: for each position up to the lower median, a pass reads the pivot and then
//   scans the rest of the set through the one-read, one-write port of the value RAM;
//   the result then moves into the output register.
// Throughput: one value per cycle while loading; no values are taken while ranking.
// Reset: rst_ni clears count, overflow flag, sequencer and output valid;
//   the value RAM is not cleared.
// ----------------------------------------------------------------------------
// lower_median_select_unit
// Buffers a set of signed values and returns its lower median, count and
// overflow flag through a registered output stage.
// ----------------------------------------------------------------------------
module lower_median_select_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [lms_pkg::DataW-1:0]  sample_value_i,
  input  logic                             last_of_set_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [lms_pkg::DataW-1:0]  median_value_o,
  output logic [lms_pkg::OutCountW-1:0]    set_count_o,
  output logic                             overflowed_o
);
  import lms_pkg::*;

  logic     res_valid;
  logic     res_ready;
  lms_res_t res;
  logic     out_valid_q;
  lms_res_t out_q;

  lms_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_value_i),
    .last_i     (last_of_set_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // take a new result when the output register is empty or draining
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  // hold payload until the transaction completes
  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign median_value_o = out_q.median;
  assign set_count_o    = out_q.count;
  assign overflowed_o   = out_q.ovf;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks lower_median_select_unit against a lower-median predictor. A directed
// group of short sets comes first, then random sets of mixed sizes. Some of
// those sets are larger than the buffer, so values are dropped and the result
// carries the overflow flag. Both handshakes idle at random, except for one
// stretch of cycles in which neither side idles.
// ----------------------------------------------------------------------------
module testbench;
  import lms_pkg::*;

  localparam int unsigned DrainCycles  = 64;
  localparam int unsigned StallLimit   = 20000;
  localparam int unsigned RandomItems  = 700;
  localparam int unsigned CalmFirst    = 2500;
  localparam int unsigned CalmLast     = 5500;
  localparam int unsigned ShowLimit    = 10;

  typedef struct {
    logic signed [DataW-1:0] value;
    logic                    last;
  } sample_item_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic signed [DataW-1:0] sample_value_i;
  logic                    last_of_set_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic signed [DataW-1:0] median_value_o;
  logic [OutCountW-1:0]    set_count_o;
  logic                    overflowed_o;

  sample_item_t            sample_q[$];
  lms_res_t                median_q[$];

  // predictor state
  logic signed [DataW-1:0] held_values[MaxSetSize];
  int unsigned             held_count;
  logic                    dropped_seen;

  logic                    rst_done;
  logic                    in_fire;
  int unsigned             cycle_count;
  int unsigned             stall_cycles;
  int unsigned             fail_count;
  int unsigned             shown_count;

  lower_median_select_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_value_i (sample_value_i),
    .last_of_set_i  (last_of_set_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .median_value_o (median_value_o),
    .set_count_o    (set_count_o),
    .overflowed_o   (overflowed_o)
  );

  // Generate the clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Store one value; on the set's last value rank the stored ones and queue the result
  task automatic rank_sample(input logic signed [DataW-1:0] value, input logic last);
    logic signed [DataW-1:0] ranked[$];
    lms_res_t                res;
    int unsigned             k;
    if (held_count < MaxSetSize) begin
      held_values[held_count] = value;
      held_count++;
    end else begin
      dropped_seen = 1'b1;
    end
    if (last) begin
      for (int unsigned i = 0; i < held_count; i++) begin
        k = 0;
        while (k < ranked.size() && ranked[k] <= held_values[i]) k++;
        ranked.insert(k, held_values[i]);
      end
      res.median = ranked[(held_count - 1) / 2];
      res.count  = OutCountW'(held_count);
      res.ovf    = dropped_seen;
      median_q.push_back(res);
      held_count   = 0;
      dropped_seen = 1'b0;
    end
  endtask

  // Count a failure; print only the first few
  task automatic note_mismatch(input string what, input lms_res_t want, input lms_res_t got);
    fail_count++;
    if (shown_count < ShowLimit) begin
      shown_count++;
      $write("mismatch (%s) at %0t: expected median %0d count %0d ovf %0b,",
             what, $realtime, want.median, want.count, want.ovf);
      $display(" got median %0d count %0d ovf %0b",
               got.median, got.count, got.ovf);
    end
  endtask

  // Pick a value: full random, small, extreme, or a repeat of the previous one
  function automatic logic signed [DataW-1:0] pick_value(input logic signed [DataW-1:0] prev);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 50) return $urandom;
    else if (sel < 80) return $signed(DataW'($urandom_range(16))) - 8;
    else if (sel < 90) begin
      case ($urandom_range(3))
        0: return 32'sh7fffffff;
        1: return 32'sh80000000;
        2: return -1;
        default: return 0;
      endcase
    end
    return prev;
  endfunction

  // Queue one whole set of the given size with random content
  task automatic push_set(input int unsigned size);
    logic signed [DataW-1:0] v;
    sample_item_t            item;
    v = 0;
    for (int unsigned i = 0; i < size; i++) begin
      v = pick_value(v);
      item.value = v;
      item.last  = (i == size - 1);
      sample_q.push_back(item);
    end
  endtask

  task automatic push_item(input logic signed [DataW-1:0] value, input logic last);
    sample_item_t item;
    item.value = value;
    item.last  = last;
    sample_q.push_back(item);
  endtask

  // Stimulus and end of run
  initial begin : stim_blk
    int unsigned fed;
    int unsigned size;
    int unsigned sel;
    rst_ni     = 1'b0;
    rst_done   = 1'b0;
    fail_count = 0;
    shown_count = 0;
    held_count = 0;
    dropped_seen = 1'b0;

    // single-value sets at both extremes
    push_item(32'sh7fffffff, 1'b1);
    push_item(32'sh80000000, 1'b1);
    // two values: the lower one is the median
    push_item(0, 1'b0);
    push_item(-1, 1'b1);
    // odd set with signed spread
    push_item(5, 1'b0);
    push_item(-5, 1'b0);
    push_item(0, 1'b1);
    // alternating bit patterns and extremes together
    push_item(32'sh55555555, 1'b0);
    push_item(32'shaaaaaaaa, 1'b0);
    push_item(32'sh7fffffff, 1'b0);
    push_item(32'sh80000000, 1'b1);
    // duplicates
    push_item(7, 1'b0);
    push_item(7, 1'b0);
    push_item(-3, 1'b0);
    push_item(7, 1'b1);
    // descending order
    push_item(40, 1'b0);
    push_item(30, 1'b0);
    push_item(20, 1'b0);
    push_item(10, 1'b0);
    push_item(0, 1'b1);

    // exactly full, final value dropped, several dropped
    push_set(MaxSetSize);
    push_set(MaxSetSize + 1);
    push_set(MaxSetSize + 3);
    fed = 3 * MaxSetSize + 4;
    while (fed < RandomItems) begin
      sel = $urandom_range(99);
      if (sel < 70)      size = $urandom_range(8, 1);
      else if (sel < 90) size = $urandom_range(40, 9);
      else               size = $urandom_range(70, 60);
      push_set(size);
      fed += size;
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni   = 1'b1;
    rst_done = 1'b1;

    // wait for all stimulus, then all results, then drain
    while (sample_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (median_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    fail_count += median_q.size();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Drive input transactions at the falling edge
  always @(negedge clk_i or negedge rst_ni) begin : drive_blk
    sample_item_t next_item;
    logic         calm;
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      sample_value_i <= '0;
      last_of_set_i  <= 1'b0;
      out_ready_i    <= 1'b0;
    end else begin
      calm = (cycle_count >= CalmFirst && cycle_count < CalmLast);
      // advance to the next item once the current one is taken
      if (!in_valid_i || in_fire) begin
        if (rst_done && sample_q.size() != 0 && (calm || $urandom_range(99) >= 22)) begin
          next_item = sample_q.pop_front();
          in_valid_i     <= 1'b1;
          sample_value_i <= next_item.value;
          last_of_set_i  <= next_item.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      // stall the result side at random
      out_ready_i <= calm || ($urandom_range(99) >= 22);
    end
  end

  // Sample transactions at the rising edge, predict and check
  always @(posedge clk_i) begin : watch_blk
    lms_res_t got;
    lms_res_t want;
    in_fire <= in_valid_i && in_ready_o && rst_ni;
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;

      if (in_valid_i && in_ready_o) rank_sample(sample_value_i, last_of_set_i);

      if (out_valid_o && out_ready_i) begin
        got.median = median_value_o;
        got.count  = set_count_o;
        got.ovf    = overflowed_o;
        if (median_q.size() == 0) begin
          want = '0;
          note_mismatch("unexpected result", want, got);
        end else begin
          want = median_q.pop_front();
          if (got.median !== want.median) note_mismatch("median", want, got);
          else if (got.count !== want.count) note_mismatch("count", want, got);
          else if (got.ovf !== want.ovf) note_mismatch("overflow", want, got);
        end
      end
    end else begin
      cycle_count  <= 0;
      stall_cycles <= 0;
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (stall_cycles >= StallLimit) begin
      $display("timeout after %0d cycles without a transaction", stall_cycles);
      $display("FAIL");
      $finish;
    end
  end

endmodule
